// ===== hdl/page_mono_framebuffer_blit_assert.svh =====
// ----------------------------------------------------------------------------
// Page mono framebuffer blit assertion macros
// Concurrent assertion shorthands used by the port checker.
// ----------------------------------------------------------------------------
`ifndef PAGE_MONO_FRAMEBUFFER_BLIT_ASSERT_SVH
`define PAGE_MONO_FRAMEBUFFER_BLIT_ASSERT_SVH

// same-cycle implication, off during reset
`define PMFB_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off during reset
`define PMFB_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

// next-cycle implication, live during reset
`define PMFB_ASSERT_ALWAYS(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/pmfb_pkg.sv =====
// ----------------------------------------------------------------------------
// Page mono framebuffer blit package
// Payload types, action and status codes, shared internal structs.
// ----------------------------------------------------------------------------
package pmfb_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 9;
    localparam int FW_W       = 9;
    localparam int FH_W       = 7;
    localparam int STRIDE_W   = 10;
    localparam int XDST_W     = 10;
    localparam int PAGE_W     = 8;
    localparam int CALC_W     = 17;

    localparam logic [2:0] ACT_WRITE_BYTE = 3'd0;
    localparam logic [2:0] ACT_READ_BYTE  = 3'd1;
    localparam logic [2:0] ACT_SET_PIXEL  = 3'd2;
    localparam logic [2:0] ACT_GET_PIXEL  = 3'd3;
    localparam logic [2:0] ACT_BLIT_BYTE  = 3'd4;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_GEOM  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLIT_X        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BLIT_Y        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_WIDTH  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_HEIGHT = 3'd5;

    typedef struct packed {
        logic [2:0]  action;
        logic [10:0] byte_index;
        logic [7:0]  byte_value;
        logic [7:0]  column;
        logic [5:0]  row;
        logic [2:0]  source_page;
        logic        pixel_on;
    } t_in;

    typedef struct packed {
        logic [7:0] read_byte;
        logic       pixel;
        logic [1:0] status;
    } t_out;

    typedef struct packed {
        logic              start;
        logic [PAGE_W-1:0] page;
        logic [XDST_W-1:0] x;
    } t_addr_req;

    typedef struct packed {
        logic [CALC_W-1:0] addr;
        logic              ok;
    } t_addr_rsp;

    typedef struct packed {
        logic              we;
        logic              re;
        logic [CALC_W-1:0] addr;
        logic [7:0]        wdata;
    } t_mem_req;

endpackage

// ===== hdl/pmfb_addr_unit.sv =====
// ----------------------------------------------------------------------------
// Page mono framebuffer address unit
// Shared page * stride + column calculator with store bound check.
// ----------------------------------------------------------------------------
module pmfb_addr_unit #(
    parameter int STORE_BYTES = 2048
) (
    input  logic                              i_clk,
    input  pmfb_pkg::t_addr_req               i_req,
    input  logic [pmfb_pkg::STRIDE_W-1:0]     i_stride,
    output pmfb_pkg::t_addr_rsp               o_rsp
);
    import pmfb_pkg::*;

    logic [CALC_W-1:0] n_addr;
    t_addr_rsp         r_rsp;

    assign n_addr = (CALC_W'(i_req.page) * CALC_W'(i_stride)) + CALC_W'(i_req.x);

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rsp.addr <= n_addr;
            r_rsp.ok   <= (32'(n_addr) < STORE_BYTES);
        end
    end

    assign o_rsp = r_rsp;

endmodule

// ===== hdl/pmfb_store.sv =====
// ----------------------------------------------------------------------------
// Page mono framebuffer store
// Single-port byte memory with registered read data.
// ----------------------------------------------------------------------------
module pmfb_store #(
    parameter int STORE_BYTES = 2048
) (
    input  logic               i_clk,
    input  pmfb_pkg::t_mem_req i_req,
    output logic [7:0]         o_rdata
);
    import pmfb_pkg::*;

    localparam int AW = $clog2(STORE_BYTES);

    logic [7:0] r_mem [STORE_BYTES];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.addr[AW-1:0]] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.addr[AW-1:0]];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/page_mono_framebuffer_blit.sv =====
// ----------------------------------------------------------------------------
// Page mono framebuffer blit
// Page-organized monochrome frame store with byte, pixel and blit access.
// ----------------------------------------------------------------------------
// Input channel i_in_valid / o_in_ready carries one action per transfer;
// output channel o_out_valid / i_out_ready returns one result per action.
// Configuration writes use i_cfg_we / i_cfg_index / i_cfg_data while idle.
// A sequencer walks each action through one shared address unit
// (page * stride + column) and the single-port store:
//   raw byte write or action rejected in decode : decode, then finish
//   raw byte read                     : decode (read), capture, finish
//   pixel set / get                   : decode, address, read-modify-write, finish
//   blit, one destination byte        : as pixel; two bytes repeat address and RMW
// The next input transfer is taken the cycle after the result is loaded;
// no new action is accepted before the last one's result is loaded, as the
// read-modify-write goes through the single store port.
// After reset the store is swept to zero, one byte a cycle, with o_in_ready
// low. Configuration returns to its reset values.
// A finished result sits in an output register; when the receiver stalls,
// one further action is accepted and held until that register frees up.
// ----------------------------------------------------------------------------
module page_mono_framebuffer_blit #(
    parameter int MAX_WIDTH   = 256,
    parameter int MAX_HEIGHT  = 64,
    parameter int STORE_BYTES = 2048
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  pmfb_pkg::t_in                      i_in,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output pmfb_pkg::t_out                     o_out,
    input  logic                               i_cfg_we,
    input  logic [pmfb_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [pmfb_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import pmfb_pkg::*;

    localparam int AW = $clog2(STORE_BYTES);

    typedef enum logic [5:0] {
        S_CLEAR  = 6'b000001,
        S_IDLE   = 6'b000010,
        S_DECODE = 6'b000100,
        S_ADDR   = 6'b001000,
        S_RMW    = 6'b010000,
        S_FINISH = 6'b100000
    } t_state;

    t_state              r_state,   n_state;
    logic [AW-1:0]       r_clr_cnt, n_clr_cnt;
    logic                r_out_valid, n_out_valid;
    t_out                r_out,     n_out;
    t_in                 r_item,    n_item;
    logic [1:0]          r_status,  n_status;
    logic [7:0]          r_read_byte, n_read_byte;
    logic                r_pixel,   n_pixel;
    logic [15:0]         r_mask,    n_mask;
    logic [15:0]         r_data,    n_data;
    logic                r_second,  n_second;
    logic [PAGE_W-1:0]   r_page0,   n_page0;
    logic [XDST_W-1:0]   r_xdst,    n_xdst;

    logic [FW_W-1:0]     r_frame_width;
    logic [FH_W-1:0]     r_frame_height;
    logic [FW_W-1:0]     r_blit_x;
    logic [FH_W-1:0]     r_blit_y;
    logic [FW_W-1:0]     r_source_width;
    logic [FH_W-1:0]     r_source_height;

    logic [FW_W-1:0]     w_eff;
    logic [FH_W-1:0]     h_eff;
    logic [STRIDE_W-1:0] stride;
    logic                idx_ok;
    logic                pix_in;
    logic                geom_bad;
    logic                src_out;
    logic [7:0]          row_mask;
    logic [7:0]          ys;
    logic [15:0]         mask16;
    logic [15:0]         data16;
    logic [XDST_W-1:0]   xdst;
    logic                is_blit;
    logic                need_second;
    logic [7:0]          cur_mask;
    logic [7:0]          cur_data;
    logic [7:0]          pix_bit;
    logic [7:0]          rdata;

    t_addr_req           addr_req;
    t_addr_rsp           addr_rsp;
    t_mem_req            mem_req;

    pmfb_addr_unit #(
        .STORE_BYTES (STORE_BYTES)
    ) u_addr (
        .i_clk    (i_clk),
        .i_req    (addr_req),
        .i_stride (stride),
        .o_rsp    (addr_rsp)
    );

    pmfb_store #(
        .STORE_BYTES (STORE_BYTES)
    ) u_store (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (rdata)
    );

    // geometry
    assign w_eff  = (32'(r_frame_width) > MAX_WIDTH) ? FW_W'(MAX_WIDTH) : r_frame_width;
    assign h_eff  = (32'(r_frame_height) > MAX_HEIGHT) ? FH_W'(MAX_HEIGHT) : r_frame_height;
    assign stride = (STRIDE_W'(w_eff) + STRIDE_W'(7)) & ~STRIDE_W'(7);

    assign idx_ok = (32'(r_item.byte_index) < STORE_BYTES);
    assign pix_in = (FW_W'(r_item.column) < w_eff) && (FH_W'(r_item.row) < h_eff);

    assign geom_bad = (r_source_width == '0) || (r_source_height == '0)
                   || (r_blit_x > w_eff) || (r_blit_y > h_eff)
                   || ((10'(r_source_width) + 10'(r_blit_x)) > 10'(w_eff))
                   || ((8'(r_source_height) + 8'(r_blit_y)) > 8'(h_eff));
    assign src_out  = (FW_W'(r_item.column) >= r_source_width)
                   || (FH_W'({r_item.source_page, 3'b000}) >= r_source_height);

    always_comb begin
        for (int b = 0; b < 8; b++) begin
            row_mask[b] = (FH_W'({r_item.source_page, 3'(b)}) < r_source_height);
        end
    end

    assign ys     = 8'(r_blit_y) + 8'({r_item.source_page, 3'b000});
    assign mask16 = 16'(row_mask) << ys[2:0];
    assign data16 = 16'(r_item.byte_value) << ys[2:0];
    assign xdst   = XDST_W'(r_blit_x) + XDST_W'(r_item.column);

    assign is_blit     = (r_item.action == ACT_BLIT_BYTE);
    assign need_second = is_blit && !r_second && (r_mask[15:8] != 8'd0);
    assign cur_mask    = r_second ? r_mask[15:8] : r_mask[7:0];
    assign cur_data    = r_second ? r_data[15:8] : r_data[7:0];
    assign pix_bit     = 8'd1 << r_item.row[2:0];

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_clr_cnt   = r_clr_cnt;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        n_item      = r_item;
        n_status    = r_status;
        n_read_byte = r_read_byte;
        n_pixel     = r_pixel;
        n_mask      = r_mask;
        n_data      = r_data;
        n_second    = r_second;
        n_page0     = r_page0;
        n_xdst      = r_xdst;
        addr_req    = '0;
        mem_req     = '0;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_CLEAR: begin
                mem_req.we    = 1'b1;
                mem_req.addr  = CALC_W'(r_clr_cnt);
                mem_req.wdata = 8'd0;
                n_clr_cnt     = r_clr_cnt + AW'(1);
                if (r_clr_cnt == AW'(STORE_BYTES - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_item      = i_in;
                    n_status    = ST_DONE;
                    n_read_byte = 8'd0;
                    n_pixel     = 1'b0;
                    n_second    = 1'b0;
                    n_state     = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state = S_FINISH;
                case (r_item.action)
                    ACT_WRITE_BYTE: begin
                        if (idx_ok) begin
                            mem_req.we    = 1'b1;
                            mem_req.addr  = CALC_W'(r_item.byte_index);
                            mem_req.wdata = r_item.byte_value;
                        end else begin
                            n_status = ST_RANGE;
                        end
                    end
                    ACT_READ_BYTE: begin
                        if (idx_ok) begin
                            mem_req.re   = 1'b1;
                            mem_req.addr = CALC_W'(r_item.byte_index);
                            n_state      = S_RMW;
                        end else begin
                            n_status = ST_RANGE;
                        end
                    end
                    ACT_SET_PIXEL, ACT_GET_PIXEL: begin
                        if (pix_in) begin
                            addr_req.start = 1'b1;
                            addr_req.page  = PAGE_W'(r_item.row[5:3]);
                            addr_req.x     = XDST_W'(r_item.column);
                            n_state        = S_ADDR;
                        end else begin
                            n_status = ST_RANGE;
                        end
                    end
                    ACT_BLIT_BYTE: begin
                        if (geom_bad) begin
                            n_status = ST_GEOM;
                        end else if (src_out) begin
                            n_status = ST_RANGE;
                        end else begin
                            n_mask         = mask16;
                            n_data         = data16;
                            n_page0        = PAGE_W'(ys[7:3]);
                            n_xdst         = xdst;
                            addr_req.start = 1'b1;
                            addr_req.page  = PAGE_W'(ys[7:3]);
                            addr_req.x     = xdst;
                            n_state        = S_ADDR;
                        end
                    end
                    default: begin
                        n_status = ST_RANGE;
                    end
                endcase
            end
            S_ADDR: begin
                if (addr_rsp.ok) begin
                    mem_req.re   = 1'b1;
                    mem_req.addr = addr_rsp.addr;
                    n_state      = S_RMW;
                end else begin
                    n_status = ST_RANGE;
                    if (need_second) begin
                        n_second       = 1'b1;
                        addr_req.start = 1'b1;
                        addr_req.page  = r_page0 + PAGE_W'(1);
                        addr_req.x     = r_xdst;
                    end else begin
                        n_state = S_FINISH;
                    end
                end
            end
            S_RMW: begin
                case (r_item.action)
                    ACT_READ_BYTE: begin
                        n_read_byte = rdata;
                    end
                    ACT_GET_PIXEL: begin
                        n_pixel = rdata[r_item.row[2:0]];
                    end
                    ACT_SET_PIXEL: begin
                        mem_req.we    = 1'b1;
                        mem_req.addr  = addr_rsp.addr;
                        mem_req.wdata = r_item.pixel_on ? (rdata | pix_bit)
                                                        : (rdata & ~pix_bit);
                    end
                    ACT_BLIT_BYTE: begin
                        mem_req.we    = 1'b1;
                        mem_req.addr  = addr_rsp.addr;
                        mem_req.wdata = (rdata & ~cur_mask) | (cur_data & cur_mask);
                    end
                    default: begin
                    end
                endcase
                if (need_second) begin
                    n_second       = 1'b1;
                    addr_req.start = 1'b1;
                    addr_req.page  = r_page0 + PAGE_W'(1);
                    addr_req.x     = r_xdst;
                    n_state        = S_ADDR;
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out.read_byte = r_read_byte;
                    n_out.pixel     = r_pixel;
                    n_out.status    = r_status;
                    n_out_valid     = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_CLEAR;
            r_clr_cnt       <= '0;
            r_out_valid     <= 1'b0;
            r_frame_width   <= FW_W'(128);
            r_frame_height  <= FH_W'(64);
            r_blit_x        <= '0;
            r_blit_y        <= '0;
            r_source_width  <= '0;
            r_source_height <= '0;
        end else begin
            r_state     <= n_state;
            r_clr_cnt   <= n_clr_cnt;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_FRAME_WIDTH:   r_frame_width   <= i_cfg_data[FW_W-1:0];
                    CFG_FRAME_HEIGHT:  r_frame_height  <= i_cfg_data[FH_W-1:0];
                    CFG_BLIT_X:        r_blit_x        <= i_cfg_data[FW_W-1:0];
                    CFG_BLIT_Y:        r_blit_y        <= i_cfg_data[FH_W-1:0];
                    CFG_SOURCE_WIDTH:  r_source_width  <= i_cfg_data[FW_W-1:0];
                    CFG_SOURCE_HEIGHT: r_source_height <= i_cfg_data[FH_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out       <= n_out;
        r_item      <= n_item;
        r_status    <= n_status;
        r_read_byte <= n_read_byte;
        r_pixel     <= n_pixel;
        r_mask      <= n_mask;
        r_data      <= n_data;
        r_second    <= n_second;
        r_page0     <= n_page0;
        r_xdst      <= n_xdst;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

// ===== hdl/pmfb_checker.sv =====
// ----------------------------------------------------------------------------
// Page mono framebuffer port checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
`include "page_mono_framebuffer_blit_assert.svh"

module pmfb_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           o_in_ready,
    input logic           o_out_valid,
    input logic           i_out_ready,
    input pmfb_pkg::t_out o_out
);
    import pmfb_pkg::*;

    `PMFB_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid, "result dropped while stalled")
    `PMFB_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, o_out_valid && !i_out_ready, $stable(o_out), "result changed while stalled")
    `PMFB_ASSERT_NOW(a_status_code, i_clk, i_rst_n, o_out_valid, o_out.status == ST_DONE || o_out.status == ST_RANGE || o_out.status == ST_GEOM, "undefined status")
    `PMFB_ASSERT_NOW(a_data_done, i_clk, i_rst_n, o_out_valid && (o_out.pixel || o_out.read_byte != 8'd0), o_out.status == ST_DONE, "data on failed transfer")
    `PMFB_ASSERT_ALWAYS(a_clear_busy, i_clk, !i_rst_n, !o_in_ready, "input taken during store clear")

endmodule

bind page_mono_framebuffer_blit pmfb_checker u_pmfb_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out       (o_out)
);
